FILE: sv/pcdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdg_pkg
// Types, constants and glyph tables for the rotating display column generator.
// ----------------------------------------------------------------------------
package pcdg_pkg;

    localparam int OPCODE_W   = 1;
    localparam int BYTE_W     = 8;
    localparam int SPEED_W    = 10;
    localparam int DIST_W     = 17;
    localparam int ADDR_W     = 16;
    localparam int MODE_W     = 3;
    localparam int DIGIT_W    = 4;
    localparam int SPEED_DIGITS = 3;
    localparam int DIST_DIGITS  = 5;

    // Image placement in the display memory.
    localparam logic [ADDR_W-1:0] IMAGE_BASE  = 16'd0;
    localparam logic [ADDR_W:0]   IMAGE_BYTES = 17'd11520;
    localparam logic [ADDR_W-1:0] IMAGE_LIMIT =
        ADDR_W'({1'b0, IMAGE_BASE} + IMAGE_BYTES);

    // Glyph windows, as absolute image positions.
    localparam logic [ADDR_W:0] SPEED_WIN_LO = 17'd4768 + {1'b0, IMAGE_BASE};
    localparam logic [ADDR_W:0] SPEED_WIN_HI = 17'd6752 + {1'b0, IMAGE_BASE};
    localparam logic [ADDR_W:0] DIST_WIN_LO  = 17'd4896 + {1'b0, IMAGE_BASE};
    localparam logic [ADDR_W:0] DIST_WIN_HI  = 17'd6624 + {1'b0, IMAGE_BASE};

    localparam logic [BYTE_W-1:0] ALL_LIT = 8'd255;
    localparam logic [BYTE_W-1:0] DOT_GLYPH = 8'd4;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 10'd999;
    localparam logic [DIST_W-1:0]  DIST_MAX  = 17'd99999;

    // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for every x below 2^17.
    localparam logic [18:0] DIV10_MUL   = 19'd419431;
    localparam int          DIV10_SHIFT = 22;
    localparam int          CONV_STEPS  = DIST_DIGITS;

    localparam logic [OPCODE_W-1:0] OP_TICK      = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_REV_START = 1'b1;

    localparam logic [MODE_W-1:0] MODE_IMAGE0     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IMAGE1     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALL_LIT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PHASE_TEST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIVE       = 3'd4;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_ENABLE = 1'b1;

    typedef logic [DIGIT_W-1:0] digit_t;

    localparam logic [BYTE_W-1:0] DIGIT_GLYPHS [30] = '{
        8'd124, 8'd68,  8'd124, 8'd0,   8'd124, 8'd0,   8'd92,  8'd84,  8'd116, 8'd84,
        8'd84,  8'd124, 8'd112, 8'd16,  8'd124, 8'd116, 8'd84,  8'd92,  8'd124, 8'd84,
        8'd92,  8'd64,  8'd64,  8'd124, 8'd124, 8'd84,  8'd124, 8'd112, 8'd80,  8'd124
    };

    localparam logic [BYTE_W-1:0] UNIT_GLYPHS [18] = '{
        8'd0, 8'd124, 8'd32, 8'd16, 8'd32, 8'd124,
        8'd0, 8'd4,   8'd8,  8'd16, 8'd32, 8'd64,
        8'd0, 8'd116, 8'd84, 8'd84, 8'd84, 8'd92
    };

    // Column k (0 to 2) of a decimal digit glyph.
    function automatic logic [BYTE_W-1:0] digit_glyph(input digit_t digit,
                                                      input logic [1:0] k);
        logic [5:0] idx;
        idx = 6'(digit) * 6'd3 + 6'(k);
        if (idx < 6'd30)
            return DIGIT_GLYPHS[idx[4:0]];
        else
            return '0;
    endfunction

    function automatic logic [BYTE_W-1:0] unit_glyph(input logic [4:0] idx);
        if (idx < 5'd18)
            return UNIT_GLYPHS[idx];
        else
            return '0;
    endfunction

endpackage

FILE: sv/pcdg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdg_in_if
// Input channel: column ticks and revolution starts.
// ----------------------------------------------------------------------------
interface pcdg_in_if;
    import pcdg_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   image_first_byte;
    logic [BYTE_W-1:0]   image_second_byte;
    logic [SPEED_W-1:0]  speed_centi;
    logic [DIST_W-1:0]   distance_metres;

    modport source (
        output valid, opcode, image_first_byte, image_second_byte,
               speed_centi, distance_metres,
        input  ready
    );

    modport sink (
        input  valid, opcode, image_first_byte, image_second_byte,
               speed_centi, distance_metres,
        output ready
    );
endinterface

FILE: sv/pcdg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdg_out_if
// Output channel: one column of shift register data per beat.
// ----------------------------------------------------------------------------
interface pcdg_out_if;
    import pcdg_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] first_out_byte;
    logic [BYTE_W-1:0] second_out_byte;
    logic              fet_phase;
    logic [ADDR_W-1:0] next_address;

    modport source (
        output valid, first_out_byte, second_out_byte, fet_phase, next_address,
        input  ready
    );

    modport sink (
        input  valid, first_out_byte, second_out_byte, fet_phase, next_address,
        output ready
    );
endinterface

FILE: sv/pov_column_data_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pov_column_data_generator
// Rotating display column generator: image pass-through, test patterns and
// live speed and distance glyphs rendered from decimal digits.
// ----------------------------------------------------------------------------
// An accepted beat lands in the input register and its result in the output
// register. Throughput: one beat per cycle while the output is taken and no
// conversion runs. A revolution start in live mode holds the input off while
// the digit converter divides by ten once a cycle. Reset (rst_n, asynchronous,
// low) puts the position at the image base, clears phase, digits, held glyphs
// and both registers, and empties the pipe.
module pov_column_data_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    pcdg_in_if.sink                     request,
    pcdg_out_if.source                  result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pcdg_pkg::*;

    // Configuration registers.
    logic [MODE_W-1:0] mode_reg;
    logic              enable_reg;

    // Input register.
    logic                in_valid_reg;
    logic [OPCODE_W-1:0] in_opcode_reg;
    logic [BYTE_W-1:0]   in_first_reg;
    logic [BYTE_W-1:0]   in_second_reg;
    logic [SPEED_W-1:0]  in_speed_reg;
    logic [DIST_W-1:0]   in_dist_reg;

    // Column state.
    logic [ADDR_W-1:0] pos_reg;
    logic              phase_reg;
    digit_t            speed_digits_reg [SPEED_DIGITS];
    digit_t            dist_digits_reg  [DIST_DIGITS];
    logic [BYTE_W-1:0] held_speed_reg;
    logic [BYTE_W-1:0] held_dist_reg;

    // Digit converter.
    logic              busy_reg;
    logic [2:0]        conv_cnt_reg;
    logic [SPEED_W-1:0] speed_work_reg;
    logic [DIST_W-1:0]  dist_work_reg;

    // Output register.
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_first_reg;
    logic [BYTE_W-1:0] out_second_reg;
    logic              out_phase_reg;
    logic [ADDR_W-1:0] out_addr_reg;

    logic cfg_write;
    logic advance;
    logic is_tick;
    logic tick_result;
    logic rev_start;
    logic live_mode;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE:   prdata = {29'd0, mode_reg};
            REG_ENABLE: prdata = {31'd0, enable_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IMAGE0;
            enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MODE:   mode_reg   <= pwdata[MODE_W-1:0];
                REG_ENABLE: enable_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign advance       = in_valid_reg && !busy_reg && (!out_valid_reg || result.ready);
    assign request.ready = !in_valid_reg || advance;

    assign is_tick     = (in_opcode_reg == OP_TICK);
    assign rev_start   = advance && (in_opcode_reg == OP_REV_START);
    assign tick_result = advance && is_tick && enable_reg;
    assign live_mode   = (mode_reg > MODE_PHASE_TEST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (request.ready)
            in_valid_reg <= request.valid;
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            in_opcode_reg <= request.opcode;
            in_first_reg  <= request.image_first_byte;
            in_second_reg <= request.image_second_byte;
            in_speed_reg  <= request.speed_centi;
            in_dist_reg   <= request.distance_metres;
        end
    end

    // ------------------------------------------------------------------
    // Glyph rendering
    // ------------------------------------------------------------------
    logic [ADDR_W:0]   pos_ext;
    logic              glyph_load;
    logic              speed_in_win;
    logic              dist_in_win;
    logic [ADDR_W:0]   speed_off;
    logic [ADDR_W:0]   dist_off;
    logic [5:0]        sc;
    logic [5:0]        dc;
    logic [5:0]        sc_rel;
    logic [5:0]        dc_rel;
    logic [BYTE_W-1:0] speed_glyph;
    logic [BYTE_W-1:0] dist_glyph;
    logic [BYTE_W-1:0] held_speed_next;
    logic [BYTE_W-1:0] held_dist_next;
    logic [BYTE_W-1:0] speed_row;
    logic [BYTE_W-1:0] dist_row;

    assign pos_ext      = {1'b0, pos_reg};
    assign glyph_load   = (pos_reg[4:2] == 3'd0);
    assign speed_in_win = (pos_ext >= SPEED_WIN_LO) && (pos_ext < SPEED_WIN_HI);
    assign dist_in_win  = (pos_ext >= DIST_WIN_LO) && (pos_ext < DIST_WIN_HI);
    assign speed_off    = pos_ext - SPEED_WIN_LO;
    assign dist_off     = pos_ext - DIST_WIN_LO;
    // Both windows are under 2048 bytes wide, so the column fits in six bits.
    assign sc           = speed_off[10:5];
    assign dc           = dist_off[10:5];

    always_comb
    begin
        speed_glyph = '0;
        sc_rel      = '0;
        if (sc < 6'd6)
            speed_glyph = digit_glyph(speed_digits_reg[0], sc[2:1]);
        else if (sc > 6'd7 && sc < 6'd10)
            speed_glyph = DOT_GLYPH;
        else if (sc > 6'd11 && sc < 6'd18)
        begin
            sc_rel      = sc - 6'd12;
            speed_glyph = digit_glyph(speed_digits_reg[1], sc_rel[2:1]);
        end
        else if (sc > 6'd19 && sc < 6'd26)
        begin
            sc_rel      = sc - 6'd20;
            speed_glyph = digit_glyph(speed_digits_reg[2], sc_rel[2:1]);
        end
        else if (sc > 6'd25 && sc < 6'd62)
        begin
            sc_rel      = sc - 6'd26;
            speed_glyph = unit_glyph(sc_rel[5:1]);
        end
    end

    always_comb
    begin
        dist_glyph = '0;
        dc_rel     = '0;
        if (dc < 6'd38 && dc[2:0] < 3'd6)
            dist_glyph = digit_glyph(dist_digits_reg[dc[5:3]], dc[2:1]);
        else if (dc > 6'd41 && dc < 6'd54)
        begin
            dc_rel     = dc - 6'd42;
            dist_glyph = unit_glyph(dc_rel[5:1]);
        end
    end

    assign held_speed_next = (speed_in_win && glyph_load) ? speed_glyph : held_speed_reg;
    assign held_dist_next  = (dist_in_win && glyph_load) ? dist_glyph : held_dist_reg;
    assign speed_row = speed_in_win ? (held_speed_next >> phase_reg) : '0;
    assign dist_row  = dist_in_win ? (held_dist_next >> phase_reg) : '0;

    // ------------------------------------------------------------------
    // Column bytes and position
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [ADDR_W-1:0] pos_step;
    logic [ADDR_W-1:0] pos_next;

    always_comb
    begin
        case (mode_reg) inside
            MODE_IMAGE0, MODE_IMAGE1:
            begin
                first_byte  = in_first_reg;
                second_byte = in_second_reg;
            end
            MODE_ALL_LIT:
            begin
                first_byte  = ALL_LIT;
                second_byte = ALL_LIT;
            end
            MODE_PHASE_TEST:
            begin
                first_byte  = {phase_reg, 7'd0};
                second_byte = '0;
            end
            default:
            begin
                first_byte  = speed_row;
                second_byte = dist_row;
            end
        endcase
    end

    assign pos_step = pos_reg + 16'd2;
    assign pos_next = (pos_step == IMAGE_LIMIT) ? IMAGE_BASE : pos_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= IMAGE_BASE;
            phase_reg      <= 1'b0;
            held_speed_reg <= '0;
            held_dist_reg  <= '0;
        end
        else if (rev_start)
        begin
            pos_reg   <= IMAGE_BASE;
            phase_reg <= 1'b0;
        end
        else if (tick_result)
        begin
            pos_reg   <= pos_next;
            phase_reg <= !phase_reg;
            if (live_mode)
            begin
                held_speed_reg <= held_speed_next;
                held_dist_reg  <= held_dist_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Digit converter: one divide by ten per cycle, least significant
    // digit first, shifted in at slot 0 so it ends in the last slot.
    // ------------------------------------------------------------------
    logic [28:0]        speed_prod;
    logic [35:0]        dist_prod;
    logic [6:0]         speed_quot;
    logic [13:0]        dist_quot;
    logic [SPEED_W-1:0] speed_tens;
    logic [DIST_W-1:0]  dist_tens;
    digit_t             speed_rem;
    digit_t             dist_rem;

    assign speed_prod = 29'(speed_work_reg) * 29'(DIV10_MUL);
    assign dist_prod  = 36'(dist_work_reg) * 36'(DIV10_MUL);
    assign speed_quot = speed_prod[DIV10_SHIFT+6:DIV10_SHIFT];
    assign dist_quot  = dist_prod[DIV10_SHIFT+13:DIV10_SHIFT];
    assign speed_tens = (SPEED_W'(speed_quot) << 3) + (SPEED_W'(speed_quot) << 1);
    assign dist_tens  = (DIST_W'(dist_quot) << 3) + (DIST_W'(dist_quot) << 1);
    assign speed_rem  = DIGIT_W'(speed_work_reg - speed_tens);
    assign dist_rem   = DIGIT_W'(dist_work_reg - dist_tens);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            conv_cnt_reg <= '0;
        end
        else if (rev_start && mode_reg == MODE_LIVE)
        begin
            busy_reg     <= 1'b1;
            conv_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            conv_cnt_reg <= conv_cnt_reg + 3'd1;
            if (conv_cnt_reg == 3'(CONV_STEPS - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rev_start && mode_reg == MODE_LIVE)
        begin
            speed_work_reg <= (in_speed_reg > SPEED_MAX) ? SPEED_MAX : in_speed_reg;
            dist_work_reg  <= (in_dist_reg > DIST_MAX) ? DIST_MAX : in_dist_reg;
        end
        else if (busy_reg)
        begin
            speed_work_reg <= SPEED_W'(speed_quot);
            dist_work_reg  <= DIST_W'(dist_quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SPEED_DIGITS; i++)
                speed_digits_reg[i] <= '0;
            for (int i = 0; i < DIST_DIGITS; i++)
                dist_digits_reg[i] <= '0;
        end
        else if (busy_reg)
        begin
            if (conv_cnt_reg < 3'(SPEED_DIGITS))
            begin
                speed_digits_reg[0] <= speed_rem;
                for (int i = 1; i < SPEED_DIGITS; i++)
                    speed_digits_reg[i] <= speed_digits_reg[i-1];
            end
            dist_digits_reg[0] <= dist_rem;
            for (int i = 1; i < DIST_DIGITS; i++)
                dist_digits_reg[i] <= dist_digits_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tick_result)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_result)
        begin
            out_first_reg  <= first_byte;
            out_second_reg <= second_byte;
            out_phase_reg  <= phase_reg;
            out_addr_reg   <= pos_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.first_out_byte  = out_first_reg;
    assign result.second_out_byte = out_second_reg;
    assign result.fet_phase       = out_phase_reg;
    assign result.next_address    = out_addr_reg;

`ifndef SYNTH
    // A waiting beat is held in the input register while digits are converted.
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && in_valid_reg) |-> !request.ready)
        else $error("input accepted during digit conversion");

    // Every produced column flips the phase.
    a_phase_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        tick_result |=> (phase_reg != $past(phase_reg)))
        else $error("phase did not toggle after a column");

    // The result carries the position the generator moved to.
    a_addr_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
        tick_result |=> (out_addr_reg == pos_reg))
        else $error("next address disagrees with column position");

    // The position stays inside the image.
    a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pos_reg} >= {1'b0, IMAGE_BASE})
        && ({1'b0, pos_reg} < ({1'b0, IMAGE_BASE} + IMAGE_BYTES)))
        else $error("column position left the image");

    // Conversion never runs past the last digit.
    a_conv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (conv_cnt_reg < 3'(CONV_STEPS)))
        else $error("digit converter overran");
`endif

endmodule

FILE: sim/tb_pov_column_data_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pov_column_data_generator
// Self-checking bench for the rotating display column generator. Requests
// (column ticks and revolution starts) go in through a valid/ready channel
// with random gaps, and columns are taken with random back-pressure. A
// predictor models position, phase, latched digits and held glyphs, and
// every column is checked field by field. Live-mode sweeps run the position
// through the glyph windows and around the image wrap.
// ----------------------------------------------------------------------------
module tb_pov_column_data_generator;
    import pcdg_pkg::*;

    localparam int unsigned CLK_HALF      = 2;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned END_CYCLES    = 20;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam int unsigned RANDOM_ITEMS  = 1100;
    localparam int unsigned SWEEP_TICKS   = 3400;
    localparam int unsigned WRAP_TICKS    = 5770;
    localparam int unsigned SPLIT_TICKS   = 2600;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    localparam int unsigned IMG_BASE   = 0;
    localparam int unsigned IMG_BYTES  = 11520;
    localparam logic [15:0] IMG_LIMIT  = 16'(IMG_BASE + IMG_BYTES);
    localparam int unsigned SPEED_LO   = IMG_BASE + 4768;
    localparam int unsigned SPEED_HI   = IMG_BASE + 6752;
    localparam int unsigned DIST_LO    = IMG_BASE + 4896;
    localparam int unsigned DIST_HI    = IMG_BASE + 6624;
    localparam int unsigned SPEED_CAP  = 999;
    localparam int unsigned DIST_CAP   = 99999;
    localparam logic [7:0]  FULL_BYTE  = 8'hFF;
    localparam logic [7:0]  POINT_COL  = 8'd4;

    localparam logic [7:0] DIGIT_COLS [30] = '{
        8'd124, 8'd68,  8'd124, 8'd0,   8'd124, 8'd0,   8'd92,  8'd84,  8'd116, 8'd84,
        8'd84,  8'd124, 8'd112, 8'd16,  8'd124, 8'd116, 8'd84,  8'd92,  8'd124, 8'd84,
        8'd92,  8'd64,  8'd64,  8'd124, 8'd124, 8'd84,  8'd124, 8'd112, 8'd80,  8'd124
    };

    localparam logic [7:0] UNIT_COLS [18] = '{
        8'd0, 8'd124, 8'd32, 8'd16, 8'd32, 8'd124,
        8'd0, 8'd4,   8'd8,  8'd16, 8'd32, 8'd64,
        8'd0, 8'd116, 8'd84, 8'd84, 8'd84, 8'd92
    };

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   first;
        logic [BYTE_W-1:0]   second;
        logic [SPEED_W-1:0]  speed;
        logic [DIST_W-1:0]   distance;
    } column_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
        logic              fet;
        logic [ADDR_W-1:0] addr;
    } column_beat_t;

    class column_scoreboard;
        logic [MODE_W-1:0] mode;
        logic              enable;
        logic [ADDR_W-1:0] position;
        logic              phase;
        logic [3:0]        speed_digit [SPEED_DIGITS];
        logic [3:0]        dist_digit [DIST_DIGITS];
        logic [7:0]        speed_glyph;
        logic [7:0]        dist_glyph;
        column_beat_t      expected_columns [$];
        int unsigned       errors;

        function new();
            mode = MODE_IMAGE0;
            enable = 1'b0;
            position = 16'(IMG_BASE);
            phase = 1'b0;
            foreach (speed_digit[i]) speed_digit[i] = '0;
            foreach (dist_digit[i]) dist_digit[i] = '0;
            speed_glyph = '0;
            dist_glyph = '0;
            errors = 0;
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_MODE)
                mode = value[MODE_W-1:0];
            else
                enable = value[0];
        endfunction

        function logic [7:0] digit_col(logic [3:0] digit, int unsigned k);
            int unsigned idx;
            idx = digit * 3 + k;
            return (idx < 30) ? DIGIT_COLS[idx] : 8'd0;
        endfunction

        function logic [7:0] speed_row();
            int unsigned c;
            logic [7:0] g;
            if (position < SPEED_LO || position >= SPEED_HI)
                return 8'd0;
            // The glyph is only reloaded in the first columns of each 32-byte cell.
            if (position % 32 < 4) begin
                c = (position - SPEED_LO) / 32;
                g = 8'd0;
                if (c < 6)
                    g = digit_col(speed_digit[0], c / 2);
                else if (c > 7 && c < 10)
                    g = POINT_COL;
                else if (c > 11 && c < 18)
                    g = digit_col(speed_digit[1], (c - 12) / 2);
                else if (c > 19 && c < 26)
                    g = digit_col(speed_digit[2], (c - 20) / 2);
                else if (c > 25 && c < 62)
                    g = UNIT_COLS[((c - 26) / 2) % 18];
                speed_glyph = g;
            end
            return speed_glyph >> phase;
        endfunction

        function logic [7:0] distance_row();
            int unsigned c;
            logic [7:0] g;
            if (position < DIST_LO || position >= DIST_HI)
                return 8'd0;
            if (position % 32 < 4) begin
                c = (position - DIST_LO) / 32;
                g = 8'd0;
                if (c < 38 && (c % 8) < 6)
                    g = digit_col(dist_digit[c / 8], (c % 8) / 2);
                else if (c > 41 && c < 54)
                    g = UNIT_COLS[((c - 42) / 2) % 18];
                dist_glyph = g;
            end
            return dist_glyph >> phase;
        endfunction

        function void take_request(column_req_t req);
            int unsigned s;
            int unsigned d;
            column_beat_t beat;
            if (req.opcode == OP_REV_START) begin
                phase = 1'b0;
                position = 16'(IMG_BASE);
                if (mode == MODE_LIVE) begin
                    s = (req.speed > SPEED_CAP) ? SPEED_CAP : req.speed;
                    d = (req.distance > DIST_CAP) ? DIST_CAP : req.distance;
                    for (int i = SPEED_DIGITS - 1; i >= 0; i--) begin
                        speed_digit[i] = 4'(s % 10);
                        s = s / 10;
                    end
                    for (int i = DIST_DIGITS - 1; i >= 0; i--) begin
                        dist_digit[i] = 4'(d % 10);
                        d = d / 10;
                    end
                end
                return;
            end
            if (!enable)
                return;
            beat.fet = phase;
            if (mode <= MODE_IMAGE1) begin
                beat.first = req.first;
                beat.second = req.second;
            end else if (mode == MODE_ALL_LIT) begin
                beat.first = FULL_BYTE;
                beat.second = FULL_BYTE;
            end else if (mode == MODE_PHASE_TEST) begin
                beat.first = {phase, 7'd0};
                beat.second = 8'd0;
            end else begin
                beat.first = speed_row();
                beat.second = distance_row();
            end
            phase = ~phase;
            position = position + 16'd2;
            if (position == IMG_LIMIT)
                position = 16'(IMG_BASE);
            beat.addr = position;
            expected_columns.push_back(beat);
        endfunction

        function void check_column(column_beat_t got);
            column_beat_t want;
            if (expected_columns.size() == 0) begin
                flag("unexpected beat, address", 32'hFFFF_FFFF, 32'(got.addr));
                return;
            end
            want = expected_columns.pop_front();
            if (got.first !== want.first)
                flag("first_out_byte", 32'(want.first), 32'(got.first));
            if (got.second !== want.second)
                flag("second_out_byte", 32'(want.second), 32'(got.second));
            if (got.fet !== want.fet)
                flag("fet_phase", 32'(want.fet), 32'(got.fet));
            if (got.addr !== want.addr)
                flag("next_address", 32'(want.addr), 32'(got.addr));
        endfunction

        function int unsigned pending();
            return expected_columns.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        steady;

    column_scoreboard sb = new();

    pcdg_in_if  request_if ();
    pcdg_out_if result_if ();

    pov_column_data_generator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_if.sink),
        .result  (result_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Mostly no gap, some short ones and a few long ones.
    function automatic int unsigned gap_len();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic column_req_t make_tick(logic [7:0] a, logic [7:0] b);
        column_req_t r;
        r.opcode = OP_TICK;
        r.first = a;
        r.second = b;
        r.speed = SPEED_W'($urandom);
        r.distance = DIST_W'($urandom);
        return r;
    endfunction

    function automatic column_req_t make_rev(int unsigned speed, int unsigned meters);
        column_req_t r;
        r.opcode = OP_REV_START;
        r.first = BYTE_W'($urandom);
        r.second = BYTE_W'($urandom);
        r.speed = SPEED_W'(speed);
        r.distance = DIST_W'(meters);
        return r;
    endfunction

    task automatic send_item(column_req_t req);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            request_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        request_if.valid <= 1'b1;
        request_if.opcode <= req.opcode;
        request_if.image_first_byte <= req.first;
        request_if.image_second_byte <= req.second;
        request_if.speed_centi <= req.speed;
        request_if.distance_metres <= req.distance;
        do @(posedge clk); while (!request_if.ready);
        sb.take_request(req);
    endtask

    task automatic send_ticks(int unsigned n);
        repeat (n) send_item(make_tick(BYTE_W'($urandom), BYTE_W'($urandom)));
    endtask

    // Hold the sender until every expected column is out, then let a revolution
    // start that produces no column finish its digit conversion.
    task automatic drain();
        @(negedge clk);
        request_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic idx, logic [31:0] value);
        logic [31:0] want;
        want = (idx == REG_MODE) ? 32'(value[MODE_W-1:0]) : 32'(value[0]);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        // Read the register straight back.
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            sb.flag((idx == REG_MODE) ? "display_mode read" : "display_enable read",
                    want, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [MODE_W-1:0] mode, logic en);
        drain();
        apb_write(REG_MODE, 32'(mode));
        apb_write(REG_ENABLE, 32'(en));
    endtask

    // Receiver with random back-pressure.
    initial
    begin : column_sink
        int unsigned hold;
        hold = 0;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                result_if.ready <= 1'b0;
                hold--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                hold = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            end
        end
    end

    always @(posedge clk)
    begin : column_monitor
        column_beat_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.first = result_if.first_out_byte;
            got.second = result_if.second_out_byte;
            got.fet = result_if.fet_phase;
            got.addr = result_if.next_address;
            sb.check_column(got);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((request_if.valid && request_if.ready) ||
                (result_if.valid && result_if.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned counted;
        int unsigned pick;
        logic [MODE_W-1:0] mode;
        logic en;

        steady = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        request_if.valid = 1'b0;
        request_if.opcode = OP_TICK;
        request_if.image_first_byte = '0;
        request_if.image_second_byte = '0;
        request_if.speed_centi = '0;
        request_if.distance_metres = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: out of reset the display is off and image mode is set.
        send_item(make_tick(8'hFF, 8'h00));
        send_item(make_rev(1023, 131071));
        set_config(MODE_IMAGE0, 1'b1);
        send_item(make_tick(8'h00, 8'hFF));
        send_item(make_tick(8'hFF, 8'h00));
        send_item(make_tick(8'hA5, 8'h5A));
        set_config(MODE_IMAGE1, 1'b1);
        send_item(make_tick(8'h5A, 8'hA5));
        set_config(MODE_ALL_LIT, 1'b1);
        send_ticks(2);
        set_config(MODE_PHASE_TEST, 1'b1);
        send_item(make_rev(0, 0));
        send_ticks(3);
        // Saturation boundaries on the digit latch.
        set_config(MODE_LIVE, 1'b1);
        send_item(make_rev(1023, 131071));
        send_ticks(1);
        send_item(make_rev(1000, 100000));
        send_item(make_rev(999, 99999));
        send_item(make_rev(0, 0));
        send_ticks(2);
        set_config(MODE_SPARE_HI, 1'b1);
        send_item(make_rev(5, 5));
        send_ticks(1);
        // Disabled: ticks are dropped, a revolution start still latches.
        set_config(MODE_LIVE, 1'b0);
        send_ticks(1);
        send_item(make_rev(1023, 131071));

        // Random revolutions under random settings.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            mode = (pick < 4) ? MODE_LIVE : MODE_W'($urandom_range(0, 7));
            en = ($urandom_range(0, 7) != 0);
            set_config(mode, en);
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4))
            begin
                send_item(make_rev($urandom_range(0, 1023), $urandom_range(0, 131071)));
                counted++;
                repeat ($urandom_range(1, 80))
                begin
                    if ($urandom_range(0, 29) == 0)
                    begin
                        send_item(make_rev($urandom_range(0, 1023),
                                           $urandom_range(0, 131071)));
                        counted++;
                    end
                    else
                    begin
                        send_ticks(1);
                        if (en)
                            counted++;
                    end
                end
                if ($urandom_range(0, 5) == 0)
                    drain();
            end
            steady = 1'b0;
        end

        // Live sweeps through both glyph windows; between them the digit
        // sets cover every decimal digit except 8.
        set_config(MODE_LIVE, 1'b1);
        send_item(make_rev(1023, 131071));
        send_ticks(SWEEP_TICKS);
        send_item(make_rev(12, 34567));
        send_ticks(SWEEP_TICKS);

        // A revolution start outside live mode must keep the old digits.
        set_config(MODE_SPARE_MID, 1'b1);
        send_item(make_rev(890, 12089));
        set_config(MODE_LIVE, 1'b1);
        send_ticks(SPLIT_TICKS);
        // Inside the windows: spare mode renders, image mode and a disabled
        // spell leave the held glyphs alone.
        set_config(MODE_SPARE_LO, 1'b1);
        send_ticks(40);
        set_config(MODE_IMAGE0, 1'b1);
        send_ticks(20);
        set_config(MODE_LIVE, 1'b0);
        send_ticks(5);
        set_config(MODE_LIVE, 1'b1);
        send_ticks(SWEEP_TICKS - SPLIT_TICKS);

        // Last sweep runs past the image end to see the wrap.
        steady = 1'b1;
        send_item(make_rev(890, 12089));
        steady = 1'b0;
        send_ticks(WRAP_TICKS);

        @(negedge clk);
        request_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/pcdg_pkg.sv
sv/pcdg_in_if.sv
sv/pcdg_out_if.sv
sv/pov_column_data_generator.sv
sim/tb_pov_column_data_generator.sv
